// File: hdl/mlpb_pkg.sv
// Shared types, constants and arithmetic helpers for the perceptron trainer.
// Used by mlpb_ctrl, mlpb_dp and the top level; no dependencies.
`default_nettype none
package mlpb_pkg;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_TRAIN  = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam int OUT_W = 24;
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

  typedef logic [12:0] sig_tab_t [256];

  typedef struct packed {
    logic lfsr_load;
    logic lfsr_step;
    logic fill_wr;
    logic fill_out;
    logic hid_rd;
    logic hid_sign;
    logic hid_first;
    logic hid_last;
    logic hid_upd;
    logic out_rd;
    logic out_first;
    logic out_bias;
    logic prob;
    logic e1;
    logic e2;
    logic e3;
    logic u1;
    logic u2;
    logic u3;
    logic u4;
    logic u5;
    logic ubias;
    logic step_rd;
    logic step_ld;
    logic res_clr;
    logic out_ld;
    logic want;
  } cmd_t;

  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t t;
    logic [63:0] one;
    logic [63:0] r2;
    logic [63:0] p;
    logic [63:0] neg;
    int k;
    one = 64'd1 << 30;
    r2 = (EXP_STEP_Q30 * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
    p = EXP_STEP_Q30;
    for (int m = 1; m < 256; m += 2) begin
      k = (255 - m) / 2;
      neg = udiv64(64'd4096 * p + ((one + p) >> 1), one + p);
      t[k] = neg[12:0];
      t[255 - k] = 13'(64'd4096 - neg);
      p = (p * r2 + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

  function automatic logic [12:0] sig_q12(logic signed [63:0] z);
    logic signed [15:0] c;
    if (z > 64'sd32767) c = 16'sh7FFF;
    else if (z < -64'sd32768) c = 16'sh8000;
    else c = z[15:0];
    return SIG_TABLE[{~c[15], c[14:8]}];
  endfunction

  function automatic logic signed [63:0] rnd_shift(logic signed [63:0] x, int n);
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/mlpb_dp.sv
// Datapath: weight memories, LFSR, accumulators and multipliers.
// Driven by mlpb_ctrl through cmd_t; uses mlpb_pkg.
`default_nettype none
module mlpb_dp
  import mlpb_pkg::*;
#(
  parameter int N = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire cmd_t                         cmd,
  input  wire logic [$clog2(N*(N+1))-1:0]   haddr,
  input  wire logic [$clog2(N+1)-1:0]       oaddr,
  input  wire logic [11:0]                  alpha,
  input  wire logic [14:0]                  noise,
  input  wire logic [15:0]                  seed,
  output logic      [OUT_W-1:0]             m_tdata
);

  localparam int RL = N + 1;
  localparam int HD = N * RL;
  localparam int HA_W = $clog2(HD);
  localparam int OA_W = $clog2(RL);
  localparam int NI_W = $clog2(N);
  localparam int AW = 16 + OA_W + 1;
  localparam int ZW = 30 + OA_W + 1;

  logic signed [15:0] hw_mem [HD];
  logic signed [15:0] ow_mem [RL];
  logic        [12:0] hv_mem [N];
  logic signed [37:0] st_mem [N];

  logic signed [15:0] hw_q;
  logic signed [15:0] ow_q;
  logic        [12:0] hv_q;
  logic signed [37:0] st_q;

  logic [15:0] lfsr;
  logic [15:0] lfsr_next;
  logic [30:0] fill_prod;
  logic signed [15:0] fill_w;

  logic d_hid;
  logic d_sign;
  logic d_first;
  logic d_last;
  logic d_upd;
  logic d_out;
  logic d_bias;
  logic d_ofirst;
  logic d_out2;
  logic d_ofirst2;
  logic [HA_W-1:0] d_haddr;
  logic [OA_W-1:0] d_oaddr;

  logic signed [AW-1:0] hacc;
  logic signed [AW-1:0] hacc_sum;
  logic signed [15:0]   term;
  logic signed [29:0]   prod;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] raw_t;
  logic signed [8:0]    raw_sat;

  logic        [12:0] p;
  logic        [12:0] p_new;
  logic        [22:0] q1;
  logic signed [13:0] dd;
  logic signed [23:0] e;
  logic signed [36:0] ae;
  logic        [22:0] m1;
  logic signed [15:0] wo;
  logic signed [50:0] poh;
  logic signed [39:0] m2;
  logic signed [63:0] m3;
  logic signed [24:0] he;
  logic signed [15:0] rp;
  logic signed [15:0] rn;
  logic signed [37:0] e_prod;

  logic        res_pred;
  logic signed [8:0] res_raw;
  logic [12:0] res_prob;
  logic        res_corr;

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);

  assign fill_prod = 31'(lfsr_next) * 31'(noise);
  assign fill_w = $signed(16'(fill_prod[30:16])) - $signed(16'(noise[14:1]));

  assign term = d_sign ? hw_q : -hw_q;
  assign hacc_sum = (d_first ? AW'(0) : hacc) + AW'(term);

  assign p_new = sig_q12(64'(z >>> 12));
  assign e_prod = dd * $signed({15'd0, q1});

  always_comb begin
    if (z < 0) raw_t = (z + $signed(ZW'(24'hFFFFFF))) >>> 24;
    else raw_t = z >>> 24;
    if (raw_t > ZW'(255)) raw_sat = 9'sd255;
    else if (raw_t < -ZW'(256)) raw_sat = -9'sd256;
    else raw_sat = raw_t[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_hid <= 1'b0;
      d_out <= 1'b0;
      d_out2 <= 1'b0;
    end else begin
      d_hid <= cmd.hid_rd;
      d_out <= cmd.out_rd & cmd.out_first | cmd.out_rd & ~cmd.out_first;
      d_out2 <= d_out;
    end
  end

  always_ff @(posedge clk) begin
    d_sign <= cmd.hid_sign;
    d_first <= cmd.hid_first;
    d_last <= cmd.hid_last;
    d_upd <= cmd.hid_upd;
    d_bias <= cmd.out_bias;
    d_ofirst <= cmd.out_first;
    d_ofirst2 <= d_ofirst;
    d_haddr <= haddr;
    d_oaddr <= oaddr;

    if (cmd.lfsr_load) lfsr <= (seed == 16'd0) ? 16'd1 : seed;
    else if (cmd.lfsr_step) lfsr <= lfsr_next;

    if (cmd.hid_rd) hw_q <= hw_mem[haddr];
    if (cmd.fill_wr && !cmd.fill_out) hw_mem[haddr] <= fill_w;
    else if (d_hid && d_upd) hw_mem[d_haddr] <= sat16(64'(hw_q) + 64'(d_sign ? rp : rn));

    if (cmd.out_rd) begin
      ow_q <= ow_mem[oaddr];
      hv_q <= hv_mem[oaddr[NI_W-1:0]];
    end
    if (cmd.fill_wr && cmd.fill_out) ow_mem[oaddr] <= fill_w;
    else if (cmd.u2) ow_mem[oaddr] <= sat16(64'(wo) + rnd_shift(64'(poh), 36));
    else if (cmd.ubias) ow_mem[oaddr] <= sat16(64'(ow_q) + rnd_shift(64'(ae), 24));

    if (d_hid && !d_upd) begin
      hacc <= hacc_sum;
      if (d_last) hv_mem[d_oaddr[NI_W-1:0]] <= sig_q12(64'(hacc_sum));
    end

    if (d_out) begin
      if (d_bias) prod <= 30'($signed({ow_q, 12'd0}));
      else prod <= $signed({1'b0, hv_q}) * ow_q;
    end
    if (d_out2) z <= (d_ofirst2 ? ZW'(0) : z) + ZW'(prod);

    if (cmd.prob) p <= p_new;
    if (cmd.e1) begin
      q1 <= 23'(p) * (23'd4096 - 23'(p));
      dd <= cmd.want ? $signed(14'd4096 - 14'(p)) : -$signed(14'(p));
    end
    if (cmd.e2) e <= 24'(rnd_shift(64'(e_prod), 12));
    if (cmd.e3) ae <= $signed({1'b0, alpha}) * e;
    if (cmd.u1) begin
      m1 <= 23'(hv_q) * (23'd4096 - 23'(hv_q));
      wo <= ow_q;
      poh <= ae * $signed({1'b0, hv_q});
    end
    if (cmd.u2) m2 <= $signed({1'b0, m1}) * wo;
    if (cmd.u3) m3 <= m2 * e;
    if (cmd.u4) he <= 25'(rnd_shift(m3, 36));
    if (cmd.u5) st_mem[oaddr[NI_W-1:0]] <= $signed({1'b0, alpha}) * he;
    if (cmd.step_rd) st_q <= st_mem[oaddr[NI_W-1:0]];
    if (cmd.step_ld) begin
      rp <= 16'(rnd_shift(64'(st_q), 24));
      rn <= 16'(rnd_shift(-64'(st_q), 24));
    end

    if (cmd.res_clr) begin
      res_pred <= 1'b0;
      res_raw <= '0;
      res_prob <= '0;
      res_corr <= 1'b0;
    end else begin
      if (cmd.prob) begin
        res_pred <= (p_new >= 13'd2048);
        res_raw <= raw_sat;
        res_prob <= p_new;
      end
      if (cmd.e1) res_corr <= (res_pred == cmd.want);
    end

    if (cmd.out_ld) m_tdata <= {res_corr, res_prob, res_raw, res_pred};
  end

endmodule
`default_nettype wire

// File: hdl/mlpb_ctrl.sv
// Sequencer: walks refill, forward pass and training update over the weights.
// Issues cmd_t and addresses to mlpb_dp; uses mlpb_pkg.
`default_nettype none
module mlpb_ctrl
  import mlpb_pkg::*;
#(
  parameter int N = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [N-1:0]                 in_bits,
  input  wire logic                         in_want,
  input  wire logic [1:0]                   in_op,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output cmd_t                              cmd,
  output logic      [$clog2(N*(N+1))-1:0]   haddr,
  output logic      [$clog2(N+1)-1:0]       oaddr
);

  localparam int RL = N + 1;
  localparam int HD = N * RL;
  localparam int HA_W = $clog2(HD);
  localparam int OA_W = $clog2(RL);
  localparam int NI_W = $clog2(N);
  localparam int TOT = RL + HD;
  localparam int WI_W = $clog2(TOT);

  typedef enum logic [4:0] {
    S_FILL_LOAD, S_FILL, S_IDLE, S_HID, S_OUT, S_ZWAIT, S_PROB, S_E1, S_E2, S_E3,
    S_UOUT, S_UBIAS, S_UROW, S_UHID, S_DONE, S_SHOW
  } state_t;

  state_t state, state_next;
  cmd_t cmd_next;
  logic [HA_W-1:0] haddr_next;
  logic [OA_W-1:0] oaddr_next;
  logic [HA_W-1:0] k, k_next;
  logic [OA_W-1:0] i, i_next;
  logic [OA_W-1:0] j, j_next;
  logic [WI_W-1:0] widx, widx_next;
  logic [3:0] c, c_next;
  logic [N-1:0] bits;
  logic [1:0] op;
  logic want;
  logic boot;
  logic accept;
  logic sign;

  assign accept = s_tvalid && s_tready;
  assign sign = (i == OA_W'(N)) || bits[i[NI_W-1:0]];

  always_comb begin
    state_next = state;
    cmd_next = '0;
    cmd_next.want = want;
    haddr_next = haddr;
    oaddr_next = oaddr;
    k_next = k;
    i_next = i;
    j_next = j;
    widx_next = widx;
    c_next = c;
    case (state)
      S_FILL_LOAD: begin
        cmd_next.lfsr_load = 1'b1;
        widx_next = '0;
        c_next = '0;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd_next.lfsr_step = 1'b1;
        c_next = c + 4'd1;
        if (c == 4'd15) begin
          cmd_next.fill_wr = 1'b1;
          if (widx < WI_W'(RL)) begin
            cmd_next.fill_out = 1'b1;
            oaddr_next = OA_W'(widx);
          end else begin
            haddr_next = HA_W'(widx - WI_W'(RL));
          end
          if (widx == WI_W'(TOT - 1)) state_next = boot ? S_IDLE : S_DONE;
          else widx_next = widx + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_next.res_clr = 1'b1;
          k_next = '0;
          i_next = '0;
          j_next = '0;
          if (in_op == OP_QUERY || in_op == OP_TRAIN) state_next = S_HID;
          else if (in_op == OP_REINIT) state_next = S_FILL_LOAD;
          else state_next = S_DONE;
        end
      end
      S_HID, S_UHID: begin
        cmd_next.hid_rd = 1'b1;
        cmd_next.hid_upd = (state == S_UHID);
        cmd_next.hid_sign = sign;
        cmd_next.hid_first = (i == '0);
        cmd_next.hid_last = (i == OA_W'(N));
        haddr_next = k;
        oaddr_next = j;
        k_next = k + 1'b1;
        if (i == OA_W'(N)) begin
          i_next = '0;
          j_next = j + 1'b1;
          if (state == S_UHID) begin
            c_next = '0;
            state_next = (j == OA_W'(N - 1)) ? S_DONE : S_UROW;
          end
        end else begin
          i_next = i + 1'b1;
        end
        if (state == S_HID && k == HA_W'(HD - 1)) begin
          j_next = '0;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd_next.out_rd = 1'b1;
        cmd_next.out_first = (j == '0);
        cmd_next.out_bias = (j == OA_W'(N));
        oaddr_next = j;
        c_next = '0;
        if (j == OA_W'(N)) state_next = S_ZWAIT;
        else j_next = j + 1'b1;
      end
      S_ZWAIT: begin
        c_next = c + 4'd1;
        if (c == 4'd2) state_next = S_PROB;
      end
      S_PROB: begin
        cmd_next.prob = 1'b1;
        state_next = (op == OP_TRAIN) ? S_E1 : S_DONE;
      end
      S_E1: begin
        cmd_next.e1 = 1'b1;
        state_next = S_E2;
      end
      S_E2: begin
        cmd_next.e2 = 1'b1;
        state_next = S_E3;
      end
      S_E3: begin
        cmd_next.e3 = 1'b1;
        j_next = '0;
        c_next = '0;
        state_next = S_UOUT;
      end
      S_UOUT: begin
        oaddr_next = j;
        c_next = c + 4'd1;
        case (c)
          4'd0: cmd_next.out_rd = 1'b1;
          4'd1: cmd_next.u1 = 1'b1;
          4'd2: cmd_next.u2 = 1'b1;
          4'd3: cmd_next.u3 = 1'b1;
          4'd4: cmd_next.u4 = 1'b1;
          default: begin
            cmd_next.u5 = 1'b1;
            c_next = '0;
            j_next = j + 1'b1;
            if (j == OA_W'(N - 1)) state_next = S_UBIAS;
          end
        endcase
      end
      S_UBIAS: begin
        oaddr_next = j;
        c_next = c + 4'd1;
        if (c == 4'd0) begin
          cmd_next.out_rd = 1'b1;
        end else begin
          cmd_next.ubias = 1'b1;
          j_next = '0;
          k_next = '0;
          i_next = '0;
          c_next = '0;
          state_next = S_UROW;
        end
      end
      S_UROW: begin
        oaddr_next = j;
        c_next = c + 4'd1;
        if (c == 4'd0) begin
          cmd_next.step_rd = 1'b1;
        end else begin
          cmd_next.step_ld = 1'b1;
          i_next = '0;
          state_next = S_UHID;
        end
      end
      S_DONE: begin
        if (!m_tvalid) begin
          cmd_next.out_ld = 1'b1;
          state_next = S_SHOW;
        end
      end
      S_SHOW: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL_LOAD;
      boot <= 1'b1;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
      cmd <= '0;
      k <= '0;
      i <= '0;
      j <= '0;
      widx <= '0;
      c <= '0;
    end else begin
      state <= state_next;
      cmd <= cmd_next;
      haddr <= haddr_next;
      oaddr <= oaddr_next;
      k <= k_next;
      i <= i_next;
      j <= j_next;
      widx <= widx_next;
      c <= c_next;
      s_tready <= (state_next == S_IDLE);
      if (state == S_FILL && state_next != S_FILL) boot <= 1'b0;
      if (state == S_SHOW) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (accept) begin
        bits <= in_bits;
        op <= in_op;
        want <= in_want;
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready) else $error("second item taken while busy");
  a_valid_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_ld)) else $error("result shown without load");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_wr |-> cmd.lfsr_step) else $error("weight written off the LFSR draw");
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> !m_tvalid) else $error("output register overwritten");

endmodule
`default_nettype wire

// File: hdl/mlp_one_hidden_layer_backprop.sv
// Top level: configuration registers, sequencer and datapath of the trainer.
// Depends on mlpb_pkg, mlpb_ctrl and mlpb_dp.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tdata: bits, want; tuser: op
//  m_axis   | out | tdata: predicted, raw_score, probability, correct
//  apb      | in  | 0 learning_rate, 4 init_noise, 8 init_seed
//
// Query: reads the INPUTS*(INPUTS+1) hidden and INPUTS+1 output weights, one weight a cycle.
// Train then computes the error, updates each output weight and the output bias, then each hidden row.
// Refill: draws each weight from the LFSR, one LFSR shift a cycle; also runs after reset, ready low.
// One item in flight; the next is taken while a result waits on the output register.
`default_nettype none
module mlp_one_hidden_layer_backprop
  import mlpb_pkg::*;
#(
  parameter int INPUTS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((INPUTS + 8) / 8) * 8-1:0] s_tdata,  // bits, want
  input  wire logic [1:0]                        s_tuser,  // op
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [OUT_W-1:0]                  m_tdata,  // predicted, raw_score, probability, correct
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [3:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam logic [1:0] REG_RATE = 2'd0;
  localparam logic [1:0] REG_NOISE = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  logic [11:0] learning_rate;
  logic [14:0] init_noise;
  logic [15:0] init_seed;
  cmd_t cmd;
  logic [$clog2(INPUTS*(INPUTS+1))-1:0] haddr;
  logic [$clog2(INPUTS+1)-1:0] oaddr;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= 12'd410;
      init_noise <= 15'd4096;
      init_seed <= 16'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_RATE: learning_rate <= pwdata[11:0];
        REG_NOISE: init_noise <= pwdata[14:0];
        REG_SEED: init_seed <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RATE: prdata = {20'd0, learning_rate};
      REG_NOISE: prdata = {17'd0, init_noise};
      REG_SEED: prdata = {16'd0, init_seed};
      default: prdata = '0;
    endcase
  end

  mlpb_ctrl #(.N(INPUTS)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .in_bits(s_tdata[INPUTS-1:0]),
    .in_want(s_tdata[INPUTS]),
    .in_op(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd(cmd),
    .haddr(haddr),
    .oaddr(oaddr)
  );

  mlpb_dp #(.N(INPUTS)) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .haddr(haddr),
    .oaddr(oaddr),
    .alpha(learning_rate),
    .noise(init_noise),
    .seed(init_seed),
    .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire
